### rtl/ngm_pkg.sv
package ngm_pkg;

	localparam int NUM_GROUPS  = 64;
	localparam int IDX_W       = $clog2(NUM_GROUPS);
	localparam int CNT_W       = $clog2(NUM_GROUPS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 48;
	localparam int BUCKET_W    = 32;
	localparam int BAND_W      = 7;
	localparam int DIV_STEPS   = TIME_W;
	localparam int BAND_STEPS  = BAND_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_EVENT        = 2'd0,
		OP_BEGIN_WINDOW = 2'd1,
		OP_FULL_RESET   = 2'd2,
		OP_READ_ENTRY   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_BAND_WIDTH  = 2'd0,
		CFG_BUCKET_SIZE = 2'd1,
		CFG_GROUPS      = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		opcode_t               opcode;
		logic                  is_note_on;
		logic [3:0]            midi_channel;
		logic [BAND_W-1:0]     band;
		logic [BUCKET_W-1:0]   bucket;
		logic [TIME_W-1:0]     target_time;
		logic [5:0]            entry_index;
	} cls_item_t;

	typedef struct packed {
		logic [3:0]          channel;
		logic [BAND_W-1:0]   band;
		logic [BUCKET_W-1:0] bucket;
		logic [31:0]         group_number;
		logic [31:0]         note_total;
		logic [TIME_W-1:0]   last_time;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic        accepted;
		logic        entry_active;
		slot_t       entry;
		logic [6:0]  active_count;
		logic [6:0]  peak_active;
		logic [31:0] dropped_total;
		logic [31:0] accumulated_total;
	} result_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SEARCH,
		B_RD_ISSUE,
		B_FINISH
	} back_state_t;

endpackage

### rtl/ngm_ram.sv
module ngm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, hold when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/ngm_front.sv
module ngm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic              is_note_on,
	input  logic [3:0]        midi_channel,
	input  logic [6:0]        note_number,
	input  logic [47:0]       target_time,
	input  logic [5:0]        entry_index,
	input  logic [6:0]        band_width,
	input  logic [31:0]       bucket_size,
	output logic              q_push,
	output ngm_pkg::cls_item_t q_item,
	input  logic              q_full
);
	import ngm_pkg::*;

	front_state_t        state_q, state_d;
	cls_item_t           item_q;
	logic [TIME_W-1:0]   dq_q;
	logic [BUCKET_W-1:0] rem_q;
	logic [BAND_W-1:0]   bq_q;
	logic [BAND_W-1:0]   brem_q;
	logic [STEP_W-1:0]   step_q;

	logic [BUCKET_W:0]   rem_sh;
	logic                rem_ge;
	logic [BAND_W:0]     brem_sh;
	logic                brem_ge;
	logic                accept;
	logic                needs_div;

	assign accept    = in_valid && in_ready;
	assign needs_div = (opcode_t'(opcode) == OP_EVENT) && is_note_on;

	// one quotient bit per cycle for each divider
	assign rem_sh  = {rem_q, dq_q[TIME_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, bucket_size};
	assign brem_sh = {brem_q, bq_q[BAND_W-1]};
	assign brem_ge = brem_sh >= {1'b0, band_width};

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		q_push   = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = needs_div ? F_DIV : F_PUSH;
				end
			end
			F_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// classified item toward the back part
	always_comb begin
		q_item        = item_q;
		q_item.band   = bq_q;
		q_item.bucket = dq_q[BUCKET_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the item and run both dividers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.opcode       <= opcode_t'(opcode);
			item_q.is_note_on   <= is_note_on;
			item_q.midi_channel <= midi_channel;
			item_q.band         <= '0;
			item_q.bucket       <= '0;
			item_q.target_time  <= target_time;
			item_q.entry_index  <= entry_index;
			dq_q   <= target_time;
			rem_q  <= '0;
			bq_q   <= note_number;
			brem_q <= '0;
			step_q <= '0;
		end else if (state_q == F_DIV) begin
			dq_q   <= {dq_q[TIME_W-2:0], rem_ge};
			rem_q  <= rem_ge ? BUCKET_W'(rem_sh - {1'b0, bucket_size}) : rem_sh[BUCKET_W-1:0];
			step_q <= step_q + 1'b1;
			if (step_q < STEP_W'(BAND_STEPS)) begin
				bq_q   <= {bq_q[BAND_W-2:0], brem_ge};
				brem_q <= brem_ge ? BAND_W'(brem_sh - {1'b0, band_width})
				                  : brem_sh[BAND_W-1:0];
			end
		end
	end

endmodule

### rtl/ngm_queue.sv
module ngm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ngm_pkg::cls_item_t push_item,
	output logic               full,
	input  logic               pop,
	output ngm_pkg::cls_item_t pop_item,
	output logic               not_empty
);
	import ngm_pkg::*;

	cls_item_t         slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_item  = slots_q[rd_ptr_q];

	// store on push
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/ngm_back.sv
module ngm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ngm_pkg::cls_item_t q_item,
	output logic               q_pop,
	input  logic [6:0]         groups_in_use,
	output logic               out_valid,
	input  logic               out_ready,
	output ngm_pkg::result_t   result
);
	import ngm_pkg::*;

	back_state_t      state_q, state_d;
	cls_item_t        item_q, item_d;
	logic [CNT_W-1:0] issue_q, issue_d;
	logic             cmp_vld_q, cmp_vld_d;
	logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
	logic             hit_q, hit_d;
	logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
	logic [CNT_W-1:0] alloc_q, alloc_d;
	logic [31:0]      next_gn_q, next_gn_d;
	logic [CNT_W-1:0] peak_q, peak_d;
	logic [31:0]      drop_q, drop_d;
	logic [31:0]      acc_q, acc_d;
	logic             out_vld_q, out_vld_d;
	result_t          out_q, out_d;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [SLOT_W-1:0] rd_raw;
	slot_t            rd_slot;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	slot_t            wr_slot;

	logic [CNT_W-1:0] grp_ext;
	logic [CNT_W-1:0] usable;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] idx_ext;
	logic             match;

	ngm_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(NUM_GROUPS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_slot),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign rd_slot = slot_t'(rd_raw);

	// usable size and search bound; entries below the fill count are active
	assign grp_ext = CNT_W'(groups_in_use);
	assign usable  = (grp_ext > CNT_W'(NUM_GROUPS)) ? CNT_W'(NUM_GROUPS) : grp_ext;
	assign limit   = (alloc_q < usable) ? alloc_q : usable;
	assign idx_ext = CNT_W'(item_q.entry_index);
	assign match   = cmp_vld_q
		&& rd_slot.channel == item_q.midi_channel
		&& rd_slot.band == item_q.band
		&& rd_slot.bucket == item_q.bucket;

	always_comb begin
		state_d   = state_q;
		item_d    = item_q;
		issue_d   = issue_q;
		cmp_vld_d = cmp_vld_q;
		cmp_idx_d = cmp_idx_q;
		hit_d     = hit_q;
		hit_idx_d = hit_idx_q;
		alloc_d   = alloc_q;
		next_gn_d = next_gn_q;
		peak_d    = peak_q;
		drop_d    = drop_q;
		acc_d     = acc_q;
		out_vld_d = out_vld_q && !out_ready;
		out_d     = out_q;
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = issue_q[IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = hit_idx_q;
		wr_slot   = rd_slot;

		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop     = 1'b1;
					item_d    = q_item;
					issue_d   = '0;
					cmp_vld_d = 1'b0;
					hit_d     = 1'b0;
					state_d   = B_FINISH;
					unique case (q_item.opcode)
						OP_EVENT: begin
							if (q_item.is_note_on && limit != '0) begin
								state_d = B_SEARCH;
							end
						end
						OP_READ_ENTRY: begin
							if (CNT_W'(q_item.entry_index) < usable
								&& CNT_W'(q_item.entry_index) < alloc_q) begin
								state_d = B_RD_ISSUE;
							end
						end
						OP_BEGIN_WINDOW, OP_FULL_RESET: state_d = B_FINISH;
						default: state_d = B_FINISH;
					endcase
				end
			end
			// one table read issued and one compared per cycle
			B_SEARCH: begin
				if (match) begin
					hit_d     = 1'b1;
					hit_idx_d = cmp_idx_q;
					state_d   = B_FINISH;
				end else if (issue_q < limit) begin
					rd_en     = 1'b1;
					issue_d   = issue_q + 1'b1;
					cmp_vld_d = 1'b1;
					cmp_idx_d = issue_q[IDX_W-1:0];
				end else begin
					cmp_vld_d = 1'b0;
					state_d   = B_FINISH;
				end
			end
			B_RD_ISSUE: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(item_q.entry_index);
				state_d = B_FINISH;
			end
			// update the table and counters, load the result
			B_FINISH: begin
				if (!out_vld_q || out_ready) begin
					out_d = '0;
					unique case (item_q.opcode)
						OP_EVENT: begin
							if (item_q.is_note_on) begin
								if (hit_q) begin
									wr_en              = 1'b1;
									wr_addr            = hit_idx_q;
									wr_slot            = rd_slot;
									wr_slot.note_total = rd_slot.note_total + 32'd1;
									wr_slot.last_time  = item_q.target_time;
								end else if (alloc_q < usable) begin
									wr_en                = 1'b1;
									wr_addr              = alloc_q[IDX_W-1:0];
									wr_slot.channel      = item_q.midi_channel;
									wr_slot.band         = item_q.band;
									wr_slot.bucket       = item_q.bucket;
									wr_slot.group_number = next_gn_q;
									wr_slot.note_total   = 32'd1;
									wr_slot.last_time    = item_q.target_time;
									alloc_d              = alloc_q + 1'b1;
									next_gn_d            = next_gn_q + 32'd1;
									if (alloc_d > peak_q) begin
										peak_d = alloc_d;
									end
								end
								if (wr_en) begin
									acc_d              = acc_q + 32'd1;
									out_d.accepted     = 1'b1;
									out_d.entry_active = 1'b1;
									out_d.entry        = wr_slot;
								end else begin
									drop_d = drop_q + 32'd1;
								end
							end
						end
						OP_BEGIN_WINDOW: begin
							alloc_d = '0;
						end
						OP_FULL_RESET: begin
							alloc_d   = '0;
							next_gn_d = 32'd1;
							peak_d    = '0;
							drop_d    = '0;
							acc_d     = '0;
						end
						OP_READ_ENTRY: begin
							if (idx_ext < usable) begin
								out_d.accepted = 1'b1;
								if (idx_ext < alloc_q) begin
									out_d.entry_active = 1'b1;
									out_d.entry        = rd_slot;
								end
							end
						end
						default: out_d = '0;
					endcase
					out_d.active_count      = 7'(alloc_d);
					out_d.peak_active       = 7'(peak_d);
					out_d.dropped_total     = drop_d;
					out_d.accumulated_total = acc_d;
					out_vld_d = 1'b1;
					state_d   = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cmp_vld_q <= 1'b0;
			hit_q     <= 1'b0;
			alloc_q   <= '0;
			next_gn_q <= 32'd1;
			peak_q    <= '0;
			drop_q    <= '0;
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= cmp_vld_d;
			hit_q     <= hit_d;
			alloc_q   <= alloc_d;
			next_gn_q <= next_gn_d;
			peak_q    <= peak_d;
			drop_q    <= drop_d;
			acc_q     <= acc_d;
			out_vld_q <= out_vld_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		item_q    <= item_d;
		issue_q   <= issue_d;
		cmp_idx_q <= cmp_idx_d;
		hit_idx_q <= hit_idx_d;
		out_q     <= out_d;
	end

	assign out_valid = out_vld_q;
	assign result    = out_q;

endmodule

### rtl/note_group_match_allocate.sv
// Note grouping table: note-on events are matched to an entry by channel,
// pitch band and timing bucket, or given a newly allocated entry.
// Input channel (in_valid/in_ready) carries one command per transfer: event,
// begin window, full reset or read entry. Output channel (out_valid/out_ready)
// returns exactly one result per command, in order.
// A note-on event first passes the divider (one quotient bit per cycle over
// the 48-bit sample time), then the table search, which scans active entries
// through the single read port of the table memory, and then the update.
// Other commands and note-offs skip the divider and the search. The front
// takes no new command until it has pushed the last one into the queue; a
// two-deep queue lets the divider work on the next event during the search.
// Reset clears the configuration registers to their defaults, the fill count
// and statistics; table entries beyond the fill count read as empty, so no
// clearing pass is needed. When the receiver stalls, the result is held in the
// output register, and the front keeps accepting until the queue is full.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, which the block itself does not enforce.
module note_group_match_allocate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic        is_note_on,
	input  logic [3:0]  midi_channel,
	input  logic [6:0]  note_number,
	input  logic [47:0] target_time,
	input  logic [5:0]  entry_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic        entry_active,
	output logic [3:0]  entry_channel,
	output logic [6:0]  entry_band,
	output logic [31:0] entry_bucket,
	output logic [31:0] entry_group_number,
	output logic [31:0] entry_note_total,
	output logic [47:0] entry_last_time,
	output logic [6:0]  active_count,
	output logic [6:0]  peak_active,
	output logic [31:0] dropped_total,
	output logic [31:0] accumulated_total
);
	import ngm_pkg::*;

	logic [6:0]  band_width_q;
	logic [31:0] bucket_size_q;
	logic [6:0]  groups_q;

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_not_empty;
	cls_item_t   push_item;
	cls_item_t   pop_item;
	result_t     result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_width_q  <= 7'd12;
			bucket_size_q <= 32'd64;
			groups_q      <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BAND_WIDTH:  band_width_q  <= cfg_data[6:0];
				CFG_BUCKET_SIZE: bucket_size_q <= cfg_data;
				CFG_GROUPS:      groups_q      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	ngm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.is_note_on  (is_note_on),
		.midi_channel(midi_channel),
		.note_number (note_number),
		.target_time (target_time),
		.entry_index (entry_index),
		.band_width  (band_width_q),
		.bucket_size (bucket_size_q),
		.q_push      (q_push),
		.q_item      (push_item),
		.q_full      (q_full)
	);

	ngm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (q_pop),
		.pop_item (pop_item),
		.not_empty(q_not_empty)
	);

	ngm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.groups_in_use(groups_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result       (result)
	);

	assign accepted           = result.accepted;
	assign entry_active       = result.entry_active;
	assign entry_channel      = result.entry.channel;
	assign entry_band         = result.entry.band;
	assign entry_bucket       = result.entry.bucket;
	assign entry_group_number = result.entry.group_number;
	assign entry_note_total   = result.entry.note_total;
	assign entry_last_time    = result.entry.last_time;
	assign active_count       = result.active_count;
	assign peak_active        = result.peak_active;
	assign dropped_total      = result.dropped_total;
	assign accumulated_total  = result.accumulated_total;

endmodule
